/* sv/ggc_pkg.sv */
// ----------------------------------------------------------------------------
// ggc_pkg: shared types for the greedy graph coloring block
// Item and result payloads, the decoded operation word passed from the
// front end to the back end, and the back end state encoding.
// ----------------------------------------------------------------------------
package ggc_pkg;

    localparam int VERTEX_W  = 10;
    localparam int COLOR_W   = 6;
    localparam int USED_W    = 7;
    localparam int COUNT_W   = 11;
    localparam logic [COUNT_W-1:0] COUNT_RESET = 11'd1024;

    typedef struct packed {
        logic                new_graph;
        logic [VERTEX_W-1:0] neighbor;
        logic                has_neighbor;
        logic                vertex_end;
    } t_in_item;

    typedef struct packed {
        logic [VERTEX_W-1:0] vertex;
        logic [COLOR_W-1:0]  color;
        logic [USED_W-1:0]   colors_used;
        logic                graph_done;
        logic                overflow;
    } t_out_item;

    // decoded request: which steps the back end runs for it
    typedef struct packed {
        logic                clear;
        logic                open;
        logic                mark;
        logic                result;
        logic [VERTEX_W-1:0] neighbor;
    } t_op;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_OPEN,
        S_PICK,
        S_MARK,
        S_WRITE,
        S_RESULT
    } t_back_state;

endpackage

/* sv/ggc_ram.sv */
// ----------------------------------------------------------------------------
// ggc_ram: generic single write port, single read port RAM
// Registered read data, no reset on the array.
// ----------------------------------------------------------------------------
module ggc_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* sv/ggc_queue.sv */
// ----------------------------------------------------------------------------
// ggc_queue: short request queue between front and back end
// Small circular buffer of decoded requests; depth is a power of two.
// ----------------------------------------------------------------------------
module ggc_queue #(
    parameter int DEPTH = 2
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_wr,
    input  ggc_pkg::t_op  i_data,
    output logic          o_full,
    output logic          o_valid,
    input  logic          i_rd,
    output ggc_pkg::t_op  o_data
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    ggc_pkg::t_op    r_mem [DEPTH];
    logic [PW-1:0]   r_wp, n_wp;
    logic [PW-1:0]   r_rp, n_rp;
    logic [CW-1:0]   r_cnt, n_cnt;

    always_comb begin
        n_wp  = r_wp;
        n_rp  = r_rp;
        n_cnt = r_cnt;
        if (i_wr) begin
            n_wp = (r_wp == PW'(DEPTH - 1)) ? '0 : r_wp + 1'b1;
        end
        if (i_rd) begin
            n_rp = (r_rp == PW'(DEPTH - 1)) ? '0 : r_rp + 1'b1;
        end
        if (i_wr && !i_rd) begin
            n_cnt = r_cnt + 1'b1;
        end else if (!i_wr && i_rd) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_mem[r_wp] <= i_data;
        end
    end

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rp];

endmodule

/* sv/ggc_front.sv */
// ----------------------------------------------------------------------------
// ggc_front: request intake and classification
// Tracks whether a vertex is open and turns each request into the list of
// steps (clear, open, mark, result) that the back end has to run.
// ----------------------------------------------------------------------------
module ggc_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  ggc_pkg::t_in_item i_item,
    input  logic              i_q_full,
    input  logic              i_hold,
    output logic              o_full,
    output logic              o_wr,
    output ggc_pkg::t_op      o_op
);

    logic r_open, n_open;
    logic open_now;
    logic accept;

    assign o_full = i_q_full || i_hold;
    assign accept = i_push && !o_full;

    // a new graph drops any vertex left open
    assign open_now = r_open && !i_item.new_graph;

    always_comb begin
        n_open = r_open;
        if (accept) begin
            n_open = !i_item.vertex_end;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_open <= 1'b0;
        end else begin
            r_open <= n_open;
        end
    end

    assign o_wr            = accept;
    assign o_op.clear      = i_item.new_graph;
    assign o_op.open       = !open_now;
    assign o_op.mark       = i_item.has_neighbor;
    assign o_op.result     = i_item.vertex_end;
    assign o_op.neighbor   = i_item.neighbor;

endmodule

/* sv/ggc_back.sv */
// ----------------------------------------------------------------------------
// ggc_back: coloring engine
// Runs each request as a short sequence over the forbidden-color store:
// clear sweep, color pick at vertex open, read-modify-write per neighbor,
// and the per-vertex result into a one-entry output register.
// ----------------------------------------------------------------------------
module ggc_back #(
    parameter int MAX_VERTICES = 1024,
    parameter int MAX_COLORS   = 64
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_q_valid,
    input  ggc_pkg::t_op                        i_op,
    output logic                                o_q_pop,
    output logic                                o_init_busy,
    input  logic [ggc_pkg::COUNT_W-1:0]         i_vertex_count,
    output logic                                o_we,
    output logic [$clog2(MAX_VERTICES)-1:0]     o_waddr,
    output logic [MAX_COLORS-1:0]               o_wdata,
    output logic                                o_re,
    output logic [$clog2(MAX_VERTICES)-1:0]     o_raddr,
    input  logic [MAX_COLORS-1:0]               i_rdata,
    output logic                                o_out_valid,
    output ggc_pkg::t_out_item                  o_out,
    input  logic                                i_out_pop
);

    localparam int AW = $clog2(MAX_VERTICES);
    localparam int CW = (AW + 1 > ggc_pkg::COUNT_W) ? AW + 1 : ggc_pkg::COUNT_W;
    localparam bit IS_POW2 = ((MAX_VERTICES & (MAX_VERTICES - 1)) == 0);

    // neighbor index modulo the store depth: mask, or restoring subtracts
    function automatic logic [AW-1:0] wrap_index(
        input logic [ggc_pkg::VERTEX_W-1:0] v
    );
        int r;
        r = int'(v);
        if (IS_POW2) begin
            r = r & (MAX_VERTICES - 1);
        end else begin
            for (int k = ggc_pkg::VERTEX_W - 1; k >= 0; k--) begin
                if (r >= (MAX_VERTICES << k)) begin
                    r = r - (MAX_VERTICES << k);
                end
            end
        end
        return r[AW-1:0];
    endfunction

    function automatic ggc_pkg::t_back_state first_step(input ggc_pkg::t_op op);
        if (op.open) begin
            return ggc_pkg::S_OPEN;
        end else if (op.mark) begin
            return ggc_pkg::S_MARK;
        end else if (op.result) begin
            return ggc_pkg::S_RESULT;
        end
        return ggc_pkg::S_IDLE;
    endfunction

    ggc_pkg::t_back_state        r_state, n_state;
    ggc_pkg::t_op                r_op, n_op;
    logic [AW-1:0]               r_clr_addr, n_clr_addr;
    logic                        r_clr_resume, n_clr_resume;
    logic                        r_init, n_init;
    logic [ggc_pkg::COLOR_W-1:0] r_hc, n_hc;
    logic [ggc_pkg::COLOR_W-1:0] r_color, n_color;
    logic [AW-1:0]               r_idx, n_idx;
    logic                        r_ovf, n_ovf;
    logic                        r_out_valid, n_out_valid;
    ggc_pkg::t_out_item          r_out, n_out;

    logic [AW-1:0]               nb_addr;
    logic [CW-1:0]               vc_ext;
    logic [CW-1:0]               cnt_eff;
    logic                        done;
    logic [AW+ggc_pkg::VERTEX_W-1:0] vx_ext;
    logic [ggc_pkg::USED_W-1:0]  hc_next;
    logic                        found;
    logic [ggc_pkg::COLOR_W-1:0] pick;
    logic                        load;

    assign nb_addr = wrap_index(r_op.neighbor);
    assign vc_ext  = CW'(i_vertex_count);
    assign cnt_eff = (vc_ext == '0) ? CW'(1) :
                     (vc_ext > CW'(MAX_VERTICES)) ? CW'(MAX_VERTICES) : vc_ext;
    assign done    = (CW'(r_idx) == cnt_eff - 1'b1);
    assign vx_ext  = {{ggc_pkg::VERTEX_W{1'b0}}, r_idx};
    assign hc_next = {1'b0, r_hc} + 1'b1;

    // first free color among 0..highest, from the word just read
    always_comb begin
        found = 1'b0;
        pick  = '0;
        for (int c = MAX_COLORS - 1; c >= 0; c--) begin
            if (!i_rdata[c] && (ggc_pkg::USED_W'(c) <= {1'b0, r_hc})) begin
                found = 1'b1;
                pick  = ggc_pkg::COLOR_W'(c);
            end
        end
    end

    always_comb begin
        n_state      = r_state;
        n_op         = r_op;
        n_clr_addr   = r_clr_addr;
        n_clr_resume = r_clr_resume;
        n_init       = r_init;
        n_hc         = r_hc;
        n_color      = r_color;
        n_idx        = r_idx;
        n_ovf        = r_ovf;
        n_out        = r_out;
        o_q_pop      = 1'b0;
        o_we         = 1'b0;
        o_waddr      = r_clr_addr;
        o_wdata      = '0;
        o_re         = 1'b0;
        o_raddr      = r_idx;
        load         = 1'b0;

        unique case (r_state)
            ggc_pkg::S_CLEAR: begin
                o_we = 1'b1;
                if (r_clr_addr == AW'(MAX_VERTICES - 1)) begin
                    n_init       = 1'b0;
                    n_clr_resume = 1'b0;
                    n_state      = r_clr_resume ? first_step(r_op) : ggc_pkg::S_IDLE;
                end else begin
                    n_clr_addr = r_clr_addr + 1'b1;
                end
            end
            ggc_pkg::S_IDLE: begin
                if (i_q_valid) begin
                    o_q_pop = 1'b1;
                    n_op    = i_op;
                    if (i_op.clear) begin
                        n_hc         = '0;
                        n_idx        = '0;
                        n_ovf        = 1'b0;
                        n_color      = '0;
                        n_clr_addr   = '0;
                        n_clr_resume = 1'b1;
                        n_state      = ggc_pkg::S_CLEAR;
                    end else begin
                        n_state = first_step(i_op);
                    end
                end
            end
            ggc_pkg::S_OPEN: begin
                o_re    = 1'b1;
                n_state = ggc_pkg::S_PICK;
            end
            ggc_pkg::S_PICK: begin
                if (found) begin
                    n_color = pick;
                end else if (hc_next >= ggc_pkg::USED_W'(MAX_COLORS)) begin
                    n_ovf   = 1'b1;
                    n_color = ggc_pkg::COLOR_W'(MAX_COLORS - 1);
                end else begin
                    n_hc    = hc_next[ggc_pkg::COLOR_W-1:0];
                    n_color = hc_next[ggc_pkg::COLOR_W-1:0];
                end
                n_state = r_op.mark   ? ggc_pkg::S_MARK :
                          r_op.result ? ggc_pkg::S_RESULT : ggc_pkg::S_IDLE;
            end
            ggc_pkg::S_MARK: begin
                o_re    = 1'b1;
                o_raddr = nb_addr;
                n_state = ggc_pkg::S_WRITE;
            end
            ggc_pkg::S_WRITE: begin
                o_we    = 1'b1;
                o_waddr = nb_addr;
                o_wdata = i_rdata | ({{(MAX_COLORS - 1){1'b0}}, 1'b1} << r_color);
                n_state = r_op.result ? ggc_pkg::S_RESULT : ggc_pkg::S_IDLE;
            end
            ggc_pkg::S_RESULT: begin
                if (!r_out_valid || i_out_pop) begin
                    load              = 1'b1;
                    n_out.vertex      = vx_ext[ggc_pkg::VERTEX_W-1:0];
                    n_out.color       = r_color;
                    n_out.colors_used = hc_next;
                    n_out.graph_done  = done;
                    n_out.overflow    = r_ovf;
                    if (done || (r_idx == AW'(MAX_VERTICES - 1))) begin
                        n_idx = '0;
                    end else begin
                        n_idx = r_idx + 1'b1;
                    end
                    n_state = ggc_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = ggc_pkg::S_IDLE;
            end
        endcase

        n_out_valid = (r_out_valid && !i_out_pop) || load;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ggc_pkg::S_CLEAR;
            r_clr_addr   <= '0;
            r_clr_resume <= 1'b0;
            r_init       <= 1'b1;
            r_hc         <= '0;
            r_color      <= '0;
            r_idx        <= '0;
            r_ovf        <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_clr_addr   <= n_clr_addr;
            r_clr_resume <= n_clr_resume;
            r_init       <= n_init;
            r_hc         <= n_hc;
            r_color      <= n_color;
            r_idx        <= n_idx;
            r_ovf        <= n_ovf;
            r_out_valid  <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op  <= n_op;
        r_out <= n_out;
    end

    assign o_init_busy = r_init;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

/* sv/greedy_graph_coloring.sv */
// ----------------------------------------------------------------------------
// greedy_graph_coloring: streamed first-fit graph coloring
// Front end classifies requests into a two-deep queue; the back end colors
// vertices against a forbidden-color store held in one RAM.
// ----------------------------------------------------------------------------
// Timing: the back end works one request at a time against one store RAM
// with registered reads. It first takes the request from the queue.
// Marking a neighbor adds a read, then a write of that neighbor's word.
// Opening a vertex adds a read of the vertex's word, then the first-fit
// pick. A result adds the result step, plus any wait for a free output
// register. A request with new_graph first sweeps the store to zero. The
// same sweep runs after reset, and full stays high during it. Configuration
// writes are taken every cycle.
module greedy_graph_coloring #(
    parameter int MAX_VERTICES = 1024,
    parameter int MAX_COLORS   = 64
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        push,
    output logic                        full,
    input  ggc_pkg::t_in_item           i_in,
    output logic                        empty,
    input  logic                        pop,
    output ggc_pkg::t_out_item          o_out,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [ggc_pkg::COUNT_W-1:0] i_cfg_data
);

    localparam int AW = $clog2(MAX_VERTICES);

    logic [ggc_pkg::COUNT_W-1:0] r_vertex_count;

    logic              q_full;
    logic              q_wr;
    ggc_pkg::t_op      q_in;
    logic              q_valid;
    logic              q_pop;
    ggc_pkg::t_op      q_head;
    logic              init_busy;
    logic              out_valid;

    logic                  ram_we;
    logic [AW-1:0]         ram_waddr;
    logic [MAX_COLORS-1:0] ram_wdata;
    logic                  ram_re;
    logic [AW-1:0]         ram_raddr;
    logic [MAX_COLORS-1:0] ram_rdata;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vertex_count <= ggc_pkg::COUNT_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_vertex_count <= i_cfg_data;
        end
    end

    ggc_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_item   (i_in),
        .i_q_full (q_full),
        .i_hold   (init_busy),
        .o_full   (full),
        .o_wr     (q_wr),
        .o_op     (q_in)
    );

    ggc_queue #(
        .DEPTH (2)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (q_wr),
        .i_data  (q_in),
        .o_full  (q_full),
        .o_valid (q_valid),
        .i_rd    (q_pop),
        .o_data  (q_head)
    );

    ggc_back #(
        .MAX_VERTICES (MAX_VERTICES),
        .MAX_COLORS   (MAX_COLORS)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_q_valid      (q_valid),
        .i_op           (q_head),
        .o_q_pop        (q_pop),
        .o_init_busy    (init_busy),
        .i_vertex_count (r_vertex_count),
        .o_we           (ram_we),
        .o_waddr        (ram_waddr),
        .o_wdata        (ram_wdata),
        .o_re           (ram_re),
        .o_raddr        (ram_raddr),
        .i_rdata        (ram_rdata),
        .o_out_valid    (out_valid),
        .o_out          (o_out),
        .i_out_pop      (pop)
    );

    ggc_ram #(
        .WIDTH (MAX_COLORS),
        .DEPTH (MAX_VERTICES)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign empty = !out_valid;

    // a color handed out always lies below the count of colors in use
    a_color_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> (o_out.color < o_out.colors_used[ggc_pkg::COLOR_W-1:0]) ||
                   (o_out.colors_used == ggc_pkg::USED_W'(64)))
        else $error("result color not below colors in use");

    a_used_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> (o_out.colors_used != '0) &&
                   (o_out.colors_used <= ggc_pkg::USED_W'(MAX_COLORS)))
        else $error("colors in use out of range");

    a_no_pop_empty_queue: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> q_valid)
        else $error("request queue popped while empty");

    a_no_take_in_init: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        init_busy |-> !q_wr && !q_pop)
        else $error("request moved during store initialization");

endmodule

/* test/tb_greedy_graph_coloring.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_greedy_graph_coloring: self-checking bench for streamed graph coloring
// Streams neighbor lists of small random graphs plus a few hand-built cases
// and compares each vertex coloring against an in-bench first-fit predictor.
// ----------------------------------------------------------------------------
module tb_greedy_graph_coloring;

    localparam int MAXV          = 1024;
    localparam int MAXC          = 64;
    localparam int ITEM_TARGET   = 1250;
    localparam int STALL_LIMIT   = 6000;  // outlasts the post-reset store sweep with full high
    localparam int SETTLE_CYCLES = 40;

    logic                        clk;
    logic                        rst_n     = 1'b0;
    logic                        push      = 1'b0;
    logic                        full;
    ggc_pkg::t_in_item           drv_item  = '0;
    logic                        empty;
    logic                        pop       = 1'b0;
    ggc_pkg::t_out_item          o_out;
    logic                        cfg_valid = 1'b0;
    logic                        cfg_ready;
    logic [ggc_pkg::COUNT_W-1:0] cfg_data  = '0;

    ggc_pkg::t_in_item  pending_items[$];
    ggc_pkg::t_out_item expected_colorings[$];
    int        items_queued = 0;
    int        mismatches   = 0;
    int        stall_cycles = 0;
    int        cycle_count  = 0;

    // predictor state
    logic [MAXC-1:0]             forbid_mem[MAXV];
    int                          top_color  = 0;
    int                          cur_vertex = 0;
    int                          vert_color = 0;
    bit                          vert_open  = 0;
    bit                          sat_flag   = 0;
    logic [ggc_pkg::COUNT_W-1:0] count_reg  = ggc_pkg::COUNT_RESET;

    greedy_graph_coloring #(
        .MAX_VERTICES(MAXV),
        .MAX_COLORS  (MAXC)
    ) dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .push       (push),
        .full       (full),
        .i_in       (drv_item),
        .empty      (empty),
        .pop        (pop),
        .o_out      (o_out),
        .i_cfg_valid(cfg_valid),
        .o_cfg_ready(cfg_ready),
        .i_cfg_data (cfg_data)
    );

    initial begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial begin
        foreach (forbid_mem[i]) forbid_mem[i] = '0;
    end

    task automatic report_mismatch(input string what);
        mismatches++;
        if (mismatches <= 40) begin
            $display("MISMATCH at %0t: %s", $time, what);
        end
    endtask

    // first-fit coloring of one accepted request
    task automatic color_step(input ggc_pkg::t_in_item it);
        ggc_pkg::t_out_item res;
        bit        found;
        int        eff;
        bit        done;
        if (it.new_graph) begin
            foreach (forbid_mem[i]) forbid_mem[i] = '0;
            top_color  = 0;
            cur_vertex = 0;
            vert_color = 0;
            vert_open  = 0;
            sat_flag   = 0;
        end
        if (!vert_open) begin
            found = 0;
            for (int c = 0; c <= top_color; c++) begin
                if (!found && !forbid_mem[cur_vertex][c]) begin
                    vert_color = c;
                    found = 1;
                end
            end
            if (!found) begin
                if (top_color + 1 >= MAXC) begin
                    sat_flag   = 1;
                    vert_color = MAXC - 1;
                end else begin
                    top_color++;
                    vert_color = top_color;
                end
            end
            vert_open = 1;
        end
        if (it.has_neighbor) begin
            forbid_mem[it.neighbor][vert_color] = 1'b1;
        end
        if (it.vertex_end) begin
            eff = (count_reg == 0) ? 1 : (count_reg > MAXV) ? MAXV : int'(count_reg);
            done = (cur_vertex == eff - 1);
            res.vertex      = ggc_pkg::VERTEX_W'(cur_vertex);
            res.color       = ggc_pkg::COLOR_W'(vert_color);
            res.colors_used = ggc_pkg::USED_W'(top_color + 1);
            res.graph_done  = done;
            res.overflow    = sat_flag;
            expected_colorings.push_back(res);
            vert_open  = 0;
            cur_vertex = done ? 0 : (cur_vertex + 1) % MAXV;
        end
    endtask

    task automatic add_item(input bit ng, input int nb, input bit hn, input bit ve);
        ggc_pkg::t_in_item it;
        it.new_graph    = ng;
        it.neighbor     = ggc_pkg::VERTEX_W'(nb);
        it.has_neighbor = hn;
        it.vertex_end   = ve;
        pending_items.push_back(it);
        items_queued++;
    endtask

    // row-compressed neighbor lists of a random graph, with some noise
    task automatic queue_graph(input int nv, input int max_deg);
        bit first;
        int deg;
        int nb;
        int r;
        first = 1;
        for (int v = 0; v < nv; v++) begin
            deg = $urandom_range(max_deg);
            if ($urandom_range(19) == 0) begin
                add_item(first, $urandom_range(MAXV - 1), 0, 0);   // open only
                first = 0;
            end
            if (deg == 0) begin
                add_item(first, $urandom_range(MAXV - 1), 0, 1);
                first = 0;
            end
            for (int k = 0; k < deg; k++) begin
                r = $urandom_range(19);
                if (r == 0) nb = v;
                else if (r <= 2) nb = $urandom_range(MAXV - 1);
                else nb = $urandom_range(nv - 1);
                // rare restart in the middle of a graph
                add_item(first || ($urandom_range(399) == 0), nb, 1, k == deg - 1);
                first = 0;
            end
        end
    endtask

    task automatic write_count(input logic [ggc_pkg::COUNT_W-1:0] value);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        count_reg = value;
    endtask

    task automatic wait_drained();
        do @(posedge clk);
        while (pending_items.size() != 0 || push || expected_colorings.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    function automatic bit quiet_window();
        return (cycle_count % 8000) >= 6000;
    endfunction

    // request driver
    always @(posedge clk) begin
        if (!rst_n) begin
            push <= 1'b0;
        end else begin
            if (push && !full) begin
                color_step(drv_item);
            end
            if (!push || !full) begin
                if (pending_items.size() != 0 &&
                    (quiet_window() || $urandom_range(99) >= 25)) begin
                    push     <= 1'b1;
                    drv_item <= pending_items.pop_front();
                end else begin
                    push <= 1'b0;
                end
            end
        end
    end

    // result monitor
    always @(posedge clk) begin : monitor
        ggc_pkg::t_out_item want;
        if (!rst_n) begin
            pop <= 1'b0;
        end else begin
            if (pop && !empty) begin
                if (expected_colorings.size() == 0) begin
                    report_mismatch($sformatf("unexpected result: vertex %0d color %0d",
                                              o_out.vertex, o_out.color));
                end else begin
                    want = expected_colorings.pop_front();
                    if (o_out.vertex !== want.vertex || o_out.color !== want.color ||
                        o_out.colors_used !== want.colors_used ||
                        o_out.graph_done !== want.graph_done ||
                        o_out.overflow !== want.overflow) begin
                        report_mismatch($sformatf(
                            "vertex %0d/%0d color %0d/%0d used %0d/%0d done %0b/%0b ovf %0b/%0b",
                            o_out.vertex, want.vertex, o_out.color, want.color,
                            o_out.colors_used, want.colors_used, o_out.graph_done,
                            want.graph_done, o_out.overflow, want.overflow));
                    end
                end
            end
            pop <= quiet_window() || $urandom_range(99) >= 25;
        end
    end

    // watchdog: cycles with no request, result or register write taken
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (!rst_n || (push && !full) || (pop && !empty) || (cfg_valid && cfg_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        int cnt;
        int nv;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // reset count, no new_graph: far neighbor, self mark, open-only request
        add_item(0, MAXV - 1, 1, 0);
        add_item(0, 0, 1, 0);
        add_item(0, 5, 0, 0);
        add_item(0, 1, 1, 1);
        add_item(0, 777, 0, 1);          // vertex without neighbors
        add_item(0, 2, 1, 0);
        add_item(0, 1000, 1, 1);
        add_item(1, MAXV - 1, 1, 1);     // all fields high
        add_item(0, 0, 0, 0);
        add_item(1, 0, 0, 0);            // restart while a vertex is open
        add_item(0, 1, 1, 1);
        add_item(0, 682, 1, 0);
        add_item(0, 341, 1, 1);
        wait_drained();

        // count 0 acts as 1: each vertex is vertex 0 and marks itself,
        // so colors climb until they saturate
        write_count('0);
        add_item(1, 0, 1, 1);
        repeat (69) add_item(0, 0, 1, 1);
        wait_drained();

        write_count('1);                 // above range, clamps
        queue_graph(24, 6);
        wait_drained();

        write_count(ggc_pkg::COUNT_W'(1));
        queue_graph(4, 2);
        wait_drained();

        write_count(ggc_pkg::COUNT_W'(MAXV));
        queue_graph(12, 4);
        wait_drained();

        while (items_queued < ITEM_TARGET) begin
            case ($urandom_range(9))
                0:       cnt = $urandom_range(2047, MAXV);
                1:       cnt = $urandom_range(1);
                default: cnt = $urandom_range(40, 2);
            endcase
            write_count(ggc_pkg::COUNT_W'(cnt));
            nv = (cnt >= 2 && cnt <= 40) ? cnt : $urandom_range(30, 2);
            if ($urandom_range(3) == 0) nv += $urandom_range(6);   // run past the last vertex
            queue_graph(nv, $urandom_range(nv, 1));
            wait_drained();
        end

        if (mismatches == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
